/* hdl/assert_macros.svh */
// Assertion macros shared by the checker modules of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RFWR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RFWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rfwr_pkg.sv */
// Shared types and constants of the residual restriction block.
// No dependencies; used by the top level and the checker.
package rfwr_pkg;

  localparam int MAX_LEVEL_DEF  = 7;
  localparam int VALUE_BITS_DEF = 32;
  localparam int LEVEL_MIN      = 2;
  localparam int CFG_W          = 3;
  localparam int COORD_W        = 8;

  localparam logic [CFG_W-1:0] GRID_LEVEL_RST = 3'd7;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATHER,
    S_DRAIN,
    S_SUM,
    S_EMIT
  } state_t;

  // Stencil neighbor visited in one gather step.
  typedef enum logic [2:0] {
    NB_CENTER,
    NB_UP,
    NB_DOWN,
    NB_LEFT,
    NB_RIGHT
  } nbr_t;

  function automatic logic signed [1:0] nb_dx(nbr_t nb);
    logic signed [1:0] d;
    unique case (nb)
      NB_LEFT:  d = -2'sd1;
      NB_RIGHT: d = 2'sd1;
      default:  d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dy(nbr_t nb);
    logic signed [1:0] d;
    unique case (nb)
      NB_UP:   d = 2'sd1;
      NB_DOWN: d = -2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

/* hdl/rfwr_ram.sv */
// Simple dual-port synchronous memory: one write port, one read port,
// read data registered, valid in the cycle after the read. No dependencies.
module rfwr_ram #(
  parameter int DEPTH = 16641,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/residual_full_weight_restrict_top.sv */
// Channel  Dir  Handshake               Payload
// cfg      in   cfg_valid/cfg_ready     cfg_data: grid level
// in       in   in_tvalid/in_tready     in_tuser: mode; in_tdata: col, row, u, f
// out      out  out_tvalid/out_tready   out_tdata: coarse residual; out_tuser: saturated
//
// A write leaves the input ready. A read of an interior coarse point reaches the output
// register after 45 reads of the solution memory (5 per fine point of the 3x3 window,
// one port), then drain, sum and saturate once that register is free; other coarse
// points skip the gather. The input reopens in the cycle the result is registered.
// Reset clears control only; memory contents are undefined until written.
// A finished result waits in the output register while the next request is taken.
module residual_full_weight_restrict_top #(
  parameter int MAX_LEVEL  = rfwr_pkg::MAX_LEVEL_DEF,
  parameter int VALUE_BITS = rfwr_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rfwr_pkg::CFG_W-1:0]  cfg_data,
  input  logic in_tvalid,
  output logic in_tready,
  // col, row, u_value, f_value (lowest first), zero padded to bytes
  input  logic [((2*rfwr_pkg::COORD_W+2*VALUE_BITS+7)/8)*8-1:0] in_tdata,
  // mode
  input  logic [0:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // coarse_residual, zero padded to bytes
  output logic [((VALUE_BITS+7)/8)*8-1:0] out_tdata,
  // saturated
  output logic [0:0] out_tuser
);

  localparam int SIDE  = (1 << MAX_LEVEL) + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (MAX_LEVEL + 2 > rfwr_pkg::COORD_W + 1) ?
                         MAX_LEVEL + 2 : rfwr_pkg::COORD_W + 1;
  localparam int LW    = $clog2(MAX_LEVEL + 1);
  localparam int SW    = $clog2(2 * MAX_LEVEL - 1);
  localparam int FSW   = VALUE_BITS + 5;
  localparam int LSW   = VALUE_BITS + 8;
  localparam int DW    = LSW + 2 * MAX_LEVEL - 1;
  localparam int OTW   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CRD   = rfwr_pkg::COORD_W;

  localparam logic signed [DW-1:0] MAXV_W = (DW'(1) <<< (VALUE_BITS - 1)) - DW'(1);
  localparam logic signed [DW-1:0] MINV_W = -MAXV_W - DW'(1);

  // interior and outside the slit; nn is the number of intervals per side
  function automatic logic pt_active(logic [CW-1:0] i, logic [CW-1:0] j,
                                     logic [CW-1:0] nn);
    logic [CW-1:0] half;
    half = nn >> 1;
    return (i >= CW'(1)) && (j >= CW'(1)) && (i <= nn - CW'(1)) &&
           (j <= nn - CW'(1)) && !((j == half) && (i >= half));
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] i, logic [CW-1:0] j);
    return (AW'(j) << MAX_LEVEL) + AW'(j) + AW'(i);
  endfunction

  rfwr_pkg::state_t state_r, state_nxt;
  rfwr_pkg::nbr_t   nb_r, nb_nxt;

  logic [rfwr_pkg::CFG_W-1:0] grid_level_r;
  logic [LW-1:0]              lv;
  logic [SW-1:0]              shamt;
  logic [CW-1:0]              n_fine, m_coarse;

  logic                  in_mode;
  logic [CW-1:0]         in_colx, in_rowx;
  logic [VALUE_BITS-1:0] in_u, in_f;
  logic                  in_acc, wr_en, coarse_act;
  logic [AW-1:0]         wr_addr;

  logic [CW-1:0] ci_r, cj_r;
  logic [1:0]    px_r, py_r, px_nxt, py_nxt;
  logic [CW-1:0] pi, pj, qi, qj;
  logic [AW-1:0] rd_addr;
  logic          gather, last_step, emit_go;
  logic [1:0]    lw;

  logic          rd_vld_r, rd_act_r, rd_ctr_r;
  logic [1:0]    rd_lw_r;
  logic [VALUE_BITS-1:0] u_rdata, f_rdata;

  logic signed [LSW-1:0] lsum_r, lsum_nxt, u_term;
  logic signed [FSW-1:0] fsum_r, fsum_nxt;
  logic signed [DW-1:0]  diff_r, quo, res;
  logic                  sat;

  logic                  out_tvalid_r;
  logic [OTW-1:0]        out_tdata_r;
  logic                  out_sat_r;

  // effective level, clamped to the supported range
  always_comb begin
    if (int'(grid_level_r) < rfwr_pkg::LEVEL_MIN) begin
      lv = LW'(rfwr_pkg::LEVEL_MIN);
    end else if (int'(grid_level_r) > MAX_LEVEL) begin
      lv = LW'(MAX_LEVEL);
    end else begin
      lv = LW'(grid_level_r);
    end
  end

  assign n_fine   = CW'(1) << lv;
  assign m_coarse = n_fine >> 1;
  assign shamt    = SW'({1'b0, lv, 1'b0} - (LW + 2)'(2));

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_level_r <= rfwr_pkg::GRID_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      grid_level_r <= cfg_data;
    end
  end

  // input unpacking
  assign in_mode = in_tuser[0];
  assign in_colx = CW'(in_tdata[CRD-1:0]);
  assign in_rowx = CW'(in_tdata[2*CRD-1:CRD]);
  assign in_u    = in_tdata[2*CRD +: VALUE_BITS];
  assign in_f    = in_tdata[2*CRD+VALUE_BITS +: VALUE_BITS];

  assign in_acc     = in_tvalid && in_tready;
  assign wr_en      = in_acc && (in_mode == rfwr_pkg::MODE_WRITE) &&
                      (in_colx <= n_fine) && (in_rowx <= n_fine);
  assign wr_addr    = addr_of(in_colx, in_rowx);
  assign coarse_act = pt_active(in_colx, in_rowx, m_coarse);

  // gather sequencer: fine point (px, py) of the window, stencil neighbor nb
  assign pi = (ci_r << 1) + CW'(px_r) - CW'(1);
  assign pj = (cj_r << 1) + CW'(py_r) - CW'(1);
  assign qi = pi + CW'(rfwr_pkg::nb_dx(nb_r));
  assign qj = pj + CW'(rfwr_pkg::nb_dy(nb_r));
  assign rd_addr = addr_of(qi, qj);
  assign lw = {1'b0, px_r == 2'd1} + {1'b0, py_r == 2'd1};
  assign last_step = (px_r == 2'd2) && (py_r == 2'd2) && (nb_r == rfwr_pkg::NB_RIGHT);

  always_comb begin
    nb_nxt = nb_r;
    px_nxt = px_r;
    py_nxt = py_r;
    unique case (nb_r)
      rfwr_pkg::NB_CENTER: nb_nxt = rfwr_pkg::NB_UP;
      rfwr_pkg::NB_UP:     nb_nxt = rfwr_pkg::NB_DOWN;
      rfwr_pkg::NB_DOWN:   nb_nxt = rfwr_pkg::NB_LEFT;
      rfwr_pkg::NB_LEFT:   nb_nxt = rfwr_pkg::NB_RIGHT;
      default: begin
        nb_nxt = rfwr_pkg::NB_CENTER;
        if (px_r == 2'd2) begin
          px_nxt = 2'd0;
          py_nxt = py_r + 2'd1;
        end else begin
          px_nxt = px_r + 2'd1;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfwr_pkg::S_IDLE: begin
        if (in_acc && (in_mode == rfwr_pkg::MODE_READ)) begin
          state_nxt = coarse_act ? rfwr_pkg::S_GATHER : rfwr_pkg::S_EMIT;
        end
      end
      rfwr_pkg::S_GATHER: begin
        if (last_step) begin
          state_nxt = rfwr_pkg::S_DRAIN;
        end
      end
      rfwr_pkg::S_DRAIN: state_nxt = rfwr_pkg::S_SUM;
      rfwr_pkg::S_SUM:   state_nxt = rfwr_pkg::S_EMIT;
      rfwr_pkg::S_EMIT: begin
        if (emit_go) begin
          state_nxt = rfwr_pkg::S_IDLE;
        end
      end
      default: state_nxt = rfwr_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = (state_r == rfwr_pkg::S_IDLE);
    gather    = (state_r == rfwr_pkg::S_GATHER);
    emit_go   = (state_r == rfwr_pkg::S_EMIT) && (!out_tvalid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rfwr_pkg::S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= gather;
    end
  end

  // writes happen only while idle and reads only while gathering,
  // so the two ports never touch the same entry in one cycle
  rfwr_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_BITS), .AW(AW)) u_sol_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_u),
    .rd_en   (gather),
    .rd_addr (rd_addr),
    .rd_data (u_rdata)
  );

  rfwr_ram #(.DEPTH(DEPTH), .WIDTH(VALUE_BITS), .AW(AW)) u_rhs_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_f),
    .rd_en   (gather),
    .rd_addr (rd_addr),
    .rd_data (f_rdata)
  );

  // weights are powers of two: center 4w, neighbors -w, rhs w
  always_comb begin
    u_term   = LSW'($signed(u_rdata));
    lsum_nxt = lsum_r;
    fsum_nxt = fsum_r;
    if (rd_vld_r && rd_act_r) begin
      if (rd_ctr_r) begin
        lsum_nxt = lsum_r + (u_term <<< ({1'b0, rd_lw_r} + 3'd2));
        fsum_nxt = fsum_r + (FSW'($signed(f_rdata)) <<< rd_lw_r);
      end else begin
        lsum_nxt = lsum_r - (u_term <<< rd_lw_r);
      end
    end
  end

  // floor divide by 16, then clip to the value range
  always_comb begin
    quo = diff_r >>> 4;
    sat = 1'b1;
    if (quo > MAXV_W) begin
      res = MAXV_W;
    end else if (quo < MINV_W) begin
      res = MINV_W;
    end else begin
      res = quo;
      sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ci_r   <= in_colx;
      cj_r   <= in_rowx;
      px_r   <= 2'd0;
      py_r   <= 2'd0;
      nb_r   <= rfwr_pkg::NB_CENTER;
      lsum_r <= '0;
      fsum_r <= '0;
      diff_r <= '0;
    end else begin
      if (gather) begin
        px_r <= px_nxt;
        py_r <= py_nxt;
        nb_r <= nb_nxt;
      end
      lsum_r <= lsum_nxt;
      fsum_r <= fsum_nxt;
      if (state_r == rfwr_pkg::S_SUM) begin
        diff_r <= DW'(fsum_r) - (DW'(lsum_r) <<< shamt);
      end
    end
    rd_act_r <= pt_active(pi, pj, n_fine);
    rd_ctr_r <= (nb_r == rfwr_pkg::NB_CENTER);
    rd_lw_r  <= lw;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_tdata_r <= OTW'(res[VALUE_BITS-1:0]);
      out_sat_r   <= sat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_sat_r;

endmodule

/* hdl/rfwr_checker.sv */
// Port-level checks of the residual restriction top level, bound into it.
// Depends on rfwr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rfwr_checker #(
  parameter int VALUE_BITS = rfwr_pkg::VALUE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [0:0] in_tuser,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((VALUE_BITS+7)/8)*8-1:0] out_tdata,
  input logic [0:0] out_tuser
);

  localparam logic [VALUE_BITS-1:0] SAT_HI = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] SAT_LO = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic rd_req, wr_req, out_hold;

  assign rd_req   = in_tvalid && in_tready && (in_tuser[0] == rfwr_pkg::MODE_READ);
  assign wr_req   = in_tvalid && in_tready && (in_tuser[0] == rfwr_pkg::MODE_WRITE);
  assign out_hold = out_tvalid && !out_tready;

  `RFWR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `RFWR_ASSERT_NEXT(a_read_busy, clk, rst_n, rd_req, !in_tready, "read request did not make the block busy")
  `RFWR_ASSERT_NEXT(a_write_fast, clk, rst_n, wr_req, in_tready, "write request stalled the input")
  `RFWR_ASSERT_SAME(a_sat_value, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[VALUE_BITS-1:0] == SAT_HI || out_tdata[VALUE_BITS-1:0] == SAT_LO, "saturated result not at a range limit")

endmodule

bind residual_full_weight_restrict_top rfwr_checker #(.VALUE_BITS(VALUE_BITS)) u_rfwr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
